// ===== rtl/fspa_pkg.sv =====
`default_nettype none

package fspa_pkg;

    localparam int DEFAULT_MAX_SLOTS    = 1024;
    localparam int DEFAULT_ADDRESS_BITS = 48;

    localparam int SHIFT_W       = 4;
    localparam int COUNT_FIELD_W = 11;
    localparam int MAX_SHIFT     = 12;
    localparam int RESET_SHIFT   = 6;
    localparam int RESET_COUNT   = 1024;
    localparam int CFG_INDEX_W   = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BASE_ADDRESS = 2'd0,
        CFG_SLOT_SHIFT   = 2'd1,
        CFG_SLOT_COUNT   = 2'd2
    } cfg_index_t;

    // Width of a slot count or a link; both must hold the slot total itself,
    // which also serves as the null link.
    function automatic int fspa_count_width(input int max_slots);
        return $clog2(max_slots + 1);
    endfunction

    // Saturates a written slot count into the range 2 .. max_slots.
    function automatic logic [31:0] fspa_clamp_count(input logic [COUNT_FIELD_W-1:0] v,
                                                     input int max_slots);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide < 32'd2) begin
            return 32'd2;
        end
        if (wide > 32'(max_slots)) begin
            return 32'(max_slots);
        end
        return wide;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fspa_ram.sv =====
`default_nettype none

module fspa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fspa_rebuild.sv =====
`default_nettype none

module fspa_rebuild
    import fspa_pkg::*;
#(
    parameter int MAX_SLOTS = DEFAULT_MAX_SLOTS
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   start,
    input  wire logic [fspa_count_width(MAX_SLOTS)-1:0] count,
    output logic                                        busy,
    output logic                                        wr_en,
    output logic      [$clog2(MAX_SLOTS)-1:0]           wr_addr,
    output logic      [fspa_count_width(MAX_SLOTS)-1:0] wr_data
);

    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int LINK_W = fspa_count_width(MAX_SLOTS);

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [LINK_W-1:0] idx_wide;
    logic             last;

    assign idx_wide = LINK_W'(idx_reg);
    assign last     = (idx_reg == IDX_W'(MAX_SLOTS - 1));

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (start) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (busy_reg) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Slots 2 .. count-1 point one slot down; every other entry is null.
    assign busy    = busy_reg;
    assign wr_en   = busy_reg;
    assign wr_addr = idx_reg;
    assign wr_data = (idx_wide >= LINK_W'(2) && idx_wide < count)
                   ? idx_wide - LINK_W'(1) : LINK_W'(MAX_SLOTS);

endmodule

`default_nettype wire

// ===== rtl/fixed_slot_pool_allocator.sv =====
// Fixed-slot pool allocator with a LIFO free list held as one next-link per slot.
// Input channel (s_valid/s_ready): s_mode selects allocate (0) or release (1);
// s_release_address is the byte address to release and is ignored on allocate.
// Result channel (m_valid/m_ready): one item per input item, in order, carrying
// the allocated address (base when the list is empty, with m_out_of_memory set),
// or zero on release with m_release_rejected set for an address outside the pool.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 base address,
// 1 slot shift (saturated to 12), 2 slot count (saturated into 2..MAX_SLOTS).
// Each input item is handled in an accept cycle, which reads the head slot's link
// from the link memory, and an execute cycle, which updates the head and loads the
// output register. A new item is taken only after the previous one has executed.
// After reset, and after every write of the slot count, a sweep rewrites all
// MAX_SLOTS link entries, one per cycle; s_ready stays low while the sweep runs,
// while configuration writes are still taken.
// When the receiver stalls, the finished result waits in the output register;
// one more item may be accepted and then holds in its execute cycle until the
// output register frees.
`default_nettype none

module fixed_slot_pool_allocator
    import fspa_pkg::*;
#(
    parameter int MAX_SLOTS    = DEFAULT_MAX_SLOTS,
    parameter int ADDRESS_BITS = DEFAULT_ADDRESS_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_mode,
    input  wire logic [ADDRESS_BITS-1:0] s_release_address,

    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic      [ADDRESS_BITS-1:0] m_slot_address,
    output logic                         m_out_of_memory,
    output logic                         m_release_rejected,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ADDRESS_BITS-1:0] cfg_data
);

    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int LINK_W = fspa_count_width(MAX_SLOTS);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // Configuration registers.
    logic [ADDRESS_BITS-1:0] base_reg, base_next;
    logic [SHIFT_W-1:0]      shift_reg, shift_next;
    logic [LINK_W-1:0]       count_reg, count_next;
    logic [LINK_W-1:0]       clamped_count;

    // Control and free-list head.
    state_t                  state_reg, state_next;
    logic [LINK_W-1:0]       head_reg, head_next;

    // Item held between the accept cycle and the execute cycle.
    logic                    mode_reg, mode_next;
    logic [ADDRESS_BITS-1:0] off_reg, off_next;

    // Output register.
    logic                    m_valid_reg, m_valid_next;
    logic [ADDRESS_BITS-1:0] m_slot_address_reg, m_slot_address_next;
    logic                    m_oom_reg, m_oom_next;
    logic                    m_rej_reg, m_rej_next;

    logic                    accept;
    logic                    cfg_wr;
    logic                    count_wr;
    logic                    head_null;
    logic                    out_free;
    logic                    exec_go;
    logic                    push;
    logic [ADDRESS_BITS-1:0] alloc_addr;
    logic [ADDRESS_BITS-1:0] idx_full;
    logic                    rel_reject;

    logic                    rb_busy;
    logic                    rb_we;
    logic [IDX_W-1:0]        rb_addr;
    logic [LINK_W-1:0]       rb_data;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [LINK_W-1:0]       ram_wdata;
    logic                    ram_re;
    logic [LINK_W-1:0]       ram_rdata;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign count_wr  = cfg_wr && (cfg_index == CFG_SLOT_COUNT);
    assign clamped_count = LINK_W'(fspa_clamp_count(cfg_data[COUNT_FIELD_W-1:0], MAX_SLOTS));

    // The block takes a new item only between items and never during the sweep.
    // Since the push of a release is written in its execute cycle, before the next item can
    // be accepted, a pop never reads an entry that is still being written.
    assign s_ready   = (state_reg == ST_IDLE) && !rb_busy;
    assign accept    = s_valid && s_ready;
    assign head_null = (head_reg == NULL_LINK);
    assign ram_re    = accept && !s_mode && !head_null;

    assign out_free  = !m_valid_reg || m_ready;
    assign exec_go   = (state_reg == ST_EXEC) && out_free;

    // Allocate: slot address is base plus head scaled by the slot size.
    assign alloc_addr = base_reg + (ADDRESS_BITS'(head_reg[IDX_W-1:0]) << shift_reg);

    // Release: the offset was taken at accept; addresses below base wrap to a
    // large offset and fail the range test. Low offset bits are dropped, so an
    // unaligned address releases the slot that contains it.
    assign idx_full   = off_reg >> shift_reg;
    assign rel_reject = (idx_full >= ADDRESS_BITS'(count_reg));
    assign push       = exec_go && mode_reg && !rel_reject;

    // The sweep owns the write port while it runs and wins over a push in the same cycle.
    assign ram_we    = rb_we || push;
    assign ram_waddr = rb_we ? rb_addr : idx_full[IDX_W-1:0];
    assign ram_wdata = rb_we ? rb_data : head_reg;

    always_comb begin
        base_next  = base_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        if (cfg_wr) begin
            case (cfg_index)
                CFG_BASE_ADDRESS: begin
                    base_next = cfg_data;
                end
                CFG_SLOT_SHIFT: begin
                    shift_next = (cfg_data[SHIFT_W-1:0] > SHIFT_W'(MAX_SHIFT))
                               ? SHIFT_W'(MAX_SHIFT) : cfg_data[SHIFT_W-1:0];
                end
                CFG_SLOT_COUNT: begin
                    count_next = clamped_count;
                end
                default: begin
                    base_next = base_reg;
                end
            endcase
        end
    end

    always_comb begin
        state_next          = state_reg;
        head_next           = head_reg;
        mode_next           = mode_reg;
        off_next            = off_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_slot_address_next = m_slot_address_reg;
        m_oom_next          = m_oom_reg;
        m_rej_next          = m_rej_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mode_next  = s_mode;
                    off_next   = s_release_address - base_reg;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    m_valid_next = 1'b1;
                    if (!mode_reg) begin
                        m_rej_next = 1'b0;
                        if (head_null) begin
                            // Empty list: hand out slot zero as a dummy.
                            m_slot_address_next = base_reg;
                            m_oom_next          = 1'b1;
                        end else begin
                            m_slot_address_next = alloc_addr;
                            m_oom_next          = 1'b0;
                            head_next           = ram_rdata;
                        end
                    end else begin
                        m_slot_address_next = '0;
                        m_oom_next          = 1'b0;
                        m_rej_next          = rel_reject;
                        if (!rel_reject) begin
                            head_next = LINK_W'(idx_full[IDX_W-1:0]);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A new slot count restarts the list with the highest slot on top.
        if (count_wr) begin
            head_next = clamped_count - LINK_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= '0;
            shift_reg   <= SHIFT_W'(RESET_SHIFT);
            count_reg   <= LINK_W'(fspa_clamp_count(COUNT_FIELD_W'(RESET_COUNT), MAX_SLOTS));
            head_reg    <= LINK_W'(fspa_clamp_count(COUNT_FIELD_W'(RESET_COUNT), MAX_SLOTS))
                         - LINK_W'(1);
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            base_reg    <= base_next;
            shift_reg   <= shift_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg           <= mode_next;
        off_reg            <= off_next;
        m_slot_address_reg <= m_slot_address_next;
        m_oom_reg          <= m_oom_next;
        m_rej_reg          <= m_rej_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_slot_address     = m_slot_address_reg;
    assign m_out_of_memory    = m_oom_reg;
    assign m_release_rejected = m_rej_reg;

    fspa_rebuild #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_rebuild (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (count_wr),
        .count   (count_reg),
        .busy    (rb_busy),
        .wr_en   (rb_we),
        .wr_addr (rb_addr),
        .wr_data (rb_data)
    );

    fspa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_SLOTS)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (head_reg[IDX_W-1:0]),
        .rd_data (ram_rdata)
    );

    // A finished item always lands in the output register.
    a_exec_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_go |=> m_valid_reg)
        else $error("executed item did not reach the output register");

    // The head is always a slot index or the null link.
    a_head_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= NULL_LINK)
        else $error("free-list head outside the slot range");

    // A slot count write starts the sweep and blocks new items.
    a_count_starts_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        count_wr |=> (rb_busy && !s_ready))
        else $error("slot count write did not start the list rebuild");

    // An item stalled by a full output register stays in its execute cycle.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EXEC) && !out_free) |=> (state_reg == ST_EXEC))
        else $error("stalled item left the execute cycle");

endmodule

`default_nettype wire
